### design/llkv_pkg.sv
// ----------------------------------------------------------------------------
// llkv_pkg
// Shared types and codes for the linked-list key-value table.
// ----------------------------------------------------------------------------
package llkv_pkg;

  localparam int KEY_W   = 32;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 5;

  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_SEARCH = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;

  // read address select
  localparam logic [1:0] RD_CUR  = 2'd0;
  localparam logic [1:0] RD_NEXT = 2'd1;
  localparam logic [1:0] RD_FREE = 2'd2;

  typedef struct packed {
    logic       ready;
    logic       start;
    logic [1:0] rd_sel;
    logic       step;
    logic       hit_capture;
    logic       wr_val;
    logic       unlink;
    logic       free_push;
    logic       set_full;
    logic       alloc;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic       walk_end;
    logic       key_match;
    logic       next_end;
    logic       free_empty;
    logic       out_free;
  } sts_t;

endpackage

### design/llkv_if.sv
// ----------------------------------------------------------------------------
// llkv_if
// Request and response channels of the key-value table.
// ----------------------------------------------------------------------------
interface llkv_req_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       mode;
  logic signed [llkv_pkg::KEY_W-1:0]   key;
  logic signed [llkv_pkg::VALUE_W-1:0] value;

  modport source (output valid, output mode, output key, output value, input ready);
  modport sink   (input valid, input mode, input key, input value, output ready);
endinterface

interface llkv_rsp_if;
  logic                                valid;
  logic                                ready;
  logic                                found;
  logic signed [llkv_pkg::VALUE_W-1:0] result_value;
  logic                                status;
  logic [llkv_pkg::COUNT_W-1:0]        entry_count;

  modport source (output valid, output found, output result_value, output status,
                  output entry_count, input ready);
  modport sink   (input valid, input found, input result_value, input status,
                  input entry_count, output ready);
endinterface

### design/llkv_ram.sv
// ----------------------------------------------------------------------------
// llkv_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module llkv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/llkv_ctrl.sv
// ----------------------------------------------------------------------------
// llkv_ctrl
// Sequencer for list walk, update, unlink and allocation.
// ----------------------------------------------------------------------------
module llkv_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [1:0]       in_mode,
  input  llkv_pkg::sts_t   sts,
  output llkv_pkg::cmd_t   cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ISSUE = 3'd1;
  localparam logic [2:0] S_CMP   = 3'd2;
  localparam logic [2:0] S_PUSH  = 3'd3;
  localparam logic [2:0] S_ALLOC = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.rd_sel = llkv_pkg::RD_CUR;
    state_next = state;
    case (state)
      S_IDLE: begin
        cmd.ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          if (in_mode inside {llkv_pkg::MODE_ADD, llkv_pkg::MODE_SEARCH,
                              llkv_pkg::MODE_REMOVE}) begin
            state_next = S_ISSUE;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_ISSUE, S_CMP: begin
        if (state == S_CMP && sts.key_match) begin
          cmd.hit_capture = 1'b1;
          case (sts.mode)
            llkv_pkg::MODE_ADD: begin
              cmd.wr_val = 1'b1;
              state_next = S_DONE;
            end
            llkv_pkg::MODE_REMOVE: begin
              cmd.unlink = 1'b1;
              state_next = S_PUSH;
            end
            default: state_next = S_DONE;
          endcase
        end else if ((state == S_ISSUE && sts.walk_end) ||
                     (state == S_CMP && sts.next_end)) begin
          // key absent
          if (sts.mode == llkv_pkg::MODE_ADD) begin
            if (sts.free_empty) begin
              cmd.set_full = 1'b1;
              state_next   = S_DONE;
            end else begin
              cmd.rd_sel = llkv_pkg::RD_FREE;
              state_next = S_ALLOC;
            end
          end else begin
            state_next = S_DONE;
          end
        end else if (state == S_ISSUE) begin
          cmd.rd_sel = llkv_pkg::RD_CUR;
          state_next = S_CMP;
        end else begin
          cmd.step   = 1'b1;
          cmd.rd_sel = llkv_pkg::RD_NEXT;
        end
      end
      S_PUSH: begin
        cmd.free_push = 1'b1;
        state_next    = S_DONE;
      end
      S_ALLOC: begin
        cmd.alloc  = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

### design/llkv_dpath.sv
// ----------------------------------------------------------------------------
// llkv_dpath
// List pointers, entry memories, walk registers and response register.
// ----------------------------------------------------------------------------
module llkv_dpath #(
  parameter int CAPACITY   = 16,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  llkv_pkg::cmd_t                      cmd,
  output llkv_pkg::sts_t                      sts,
  input  logic [1:0]                          in_mode,
  input  logic signed [llkv_pkg::KEY_W-1:0]   in_key,
  input  logic signed [llkv_pkg::VALUE_W-1:0] in_value,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic                                out_found,
  output logic signed [llkv_pkg::VALUE_W-1:0] out_value,
  output logic                                out_status,
  output logic [llkv_pkg::COUNT_W-1:0]        out_count
);

  localparam int AW = $clog2(CAPACITY);
  localparam int SW = $clog2(CAPACITY + 1);
  localparam logic [SW-1:0] NULL_SLOT = SW'(CAPACITY);

  logic [1:0]            req_mode;
  logic [KEY_BITS-1:0]   req_key;
  logic [VALUE_BITS-1:0] req_val;

  logic [SW-1:0] cur, prev, steps;
  logic [SW-1:0] list_head, free_head, count, fill;

  logic                  found_w, status_w;
  logic [VALUE_BITS-1:0] res_w;

  logic [SW-1:0]         rd_addr, rd_addr_q;
  logic                  fresh_q;
  logic [KEY_BITS-1:0]   key_rd;
  logic [VALUE_BITS-1:0] val_rd;
  logic [SW-1:0]         link_rd, link_eff;

  logic          link_we;
  logic [SW-1:0] link_waddr, link_wdata;

  // slots at or above the fill mark were never written; their link reads as the next slot
  assign link_eff = fresh_q ? rd_addr_q + SW'(1) : link_rd;

  always_comb begin
    case (cmd.rd_sel)
      llkv_pkg::RD_NEXT: rd_addr = link_eff;
      llkv_pkg::RD_FREE: rd_addr = free_head;
      default:           rd_addr = cur;
    endcase
  end

  always_comb begin
    link_we    = 1'b0;
    link_waddr = cur;
    link_wdata = free_head;
    if (cmd.unlink && prev != NULL_SLOT) begin
      link_we    = 1'b1;
      link_waddr = prev;
      link_wdata = link_eff;
    end else if (cmd.free_push) begin
      link_we    = 1'b1;
      link_waddr = cur;
      link_wdata = free_head;
    end else if (cmd.alloc) begin
      link_we    = 1'b1;
      link_waddr = free_head;
      link_wdata = list_head;
    end
  end

  llkv_ram #(.WIDTH(KEY_BITS), .DEPTH(CAPACITY)) u_key_ram (
    .clk   (clk),
    .we    (cmd.alloc),
    .waddr (free_head[AW-1:0]),
    .wdata (req_key),
    .raddr (rd_addr[AW-1:0]),
    .rdata (key_rd)
  );

  llkv_ram #(.WIDTH(VALUE_BITS), .DEPTH(CAPACITY)) u_val_ram (
    .clk   (clk),
    .we    (cmd.alloc | cmd.wr_val),
    .waddr (cmd.alloc ? free_head[AW-1:0] : cur[AW-1:0]),
    .wdata (req_val),
    .raddr (rd_addr[AW-1:0]),
    .rdata (val_rd)
  );

  llkv_ram #(.WIDTH(SW), .DEPTH(CAPACITY)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr[AW-1:0]),
    .wdata (link_wdata),
    .raddr (rd_addr[AW-1:0]),
    .rdata (link_rd)
  );

  always_ff @(posedge clk) begin
    rd_addr_q <= rd_addr;
    fresh_q   <= (rd_addr >= fill);
    if (cmd.start) begin
      req_mode <= in_mode;
      req_key  <= KEY_BITS'($unsigned(in_key));
      req_val  <= VALUE_BITS'($unsigned(in_value));
      cur      <= list_head;
      prev     <= NULL_SLOT;
      steps    <= '0;
      found_w  <= 1'b0;
      status_w <= 1'b0;
      res_w    <= '0;
    end
    if (cmd.step) begin
      prev  <= cur;
      cur   <= link_eff;
      steps <= steps + SW'(1);
    end
    if (cmd.hit_capture) begin
      found_w <= 1'b1;
      res_w   <= val_rd;
    end
    if (cmd.set_full) begin
      status_w <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      list_head <= NULL_SLOT;
      free_head <= '0;
      count     <= '0;
      fill      <= '0;
    end else begin
      if (cmd.unlink && prev == NULL_SLOT) begin
        list_head <= link_eff;
      end
      if (cmd.free_push) begin
        free_head <= cur;
        if (count != '0) begin
          count <= count - SW'(1);
        end
      end
      if (cmd.alloc) begin
        free_head <= link_eff;
        list_head <= free_head;
        count     <= count + SW'(1);
        if (free_head == fill) begin
          fill <= fill + SW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_found  <= found_w;
      out_value  <= llkv_pkg::VALUE_W'($unsigned(res_w));
      out_status <= status_w;
      out_count  <= llkv_pkg::COUNT_W'(count);
    end
  end

  always_comb begin
    sts.mode       = req_mode;
    sts.walk_end   = (cur == NULL_SLOT) || (steps == NULL_SLOT);
    sts.key_match  = (key_rd == req_key);
    sts.next_end   = (link_eff == NULL_SLOT) || (steps == SW'(CAPACITY - 1));
    sts.free_empty = (free_head == NULL_SLOT);
    sts.out_free   = !out_valid || out_ready;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= NULL_SLOT && fill <= NULL_SLOT)
    else $error("entry count or fill mark beyond capacity");

  a_free_full: assert property (@(posedge clk) disable iff (rst)
    (free_head == NULL_SLOT) == (count == NULL_SLOT))
    else $error("free list state disagrees with entry count");

  a_alloc_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.alloc |=> count == $past(count) + SW'(1))
    else $error("allocation did not add an entry");

  a_found_xor_full: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_found && out_status))
    else $error("response marks both found and full");

endmodule

### design/linked_list_key_value_table.sv
// ----------------------------------------------------------------------------
// linked_list_key_value_table
// Key-value table held as a singly linked list in RAM, with a free list.
// ----------------------------------------------------------------------------
//  channel  dir  handshake     payload
//  req      in   valid/ready   mode, key, value
//  rsp      out  valid/ready   found, result_value, status, entry_count
//
//  One request at a time. A request walks the list, at most CAPACITY
//  entries, one linked entry per cycle through the registered read of
//  the entry RAMs, then does an unlink or an allocation where needed.
//  Unused modes go straight to the response.
//  Reset is synchronous; no clearing pass, so the first request may follow
//  reset at once. A stalled response holds in the output register and the
//  next request is taken meanwhile; its own response waits for it.
// ----------------------------------------------------------------------------
module linked_list_key_value_table #(
  parameter int CAPACITY   = 16,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  llkv_req_if.sink    req,
  llkv_rsp_if.source  rsp
);

  llkv_pkg::cmd_t cmd;
  llkv_pkg::sts_t sts;

  assign req.ready = cmd.ready;

  llkv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_mode  (req.mode),
    .sts      (sts),
    .cmd      (cmd)
  );

  llkv_dpath #(
    .CAPACITY   (CAPACITY),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .in_mode    (req.mode),
    .in_key     (req.key),
    .in_value   (req.value),
    .out_ready  (rsp.ready),
    .out_valid  (rsp.valid),
    .out_found  (rsp.found),
    .out_value  (rsp.result_value),
    .out_status (rsp.status),
    .out_count  (rsp.entry_count)
  );

endmodule
